### design/wrg_pkg.sv
// Shared types, constants and helper functions for the wave ripple grid block.
package wrg_pkg;

  localparam int GRID_COLS   = 64;
  localparam int GRID_ROWS   = 64;
  localparam int HEIGHT_BITS = 16;

  localparam int COL_BITS  = $clog2(GRID_COLS);
  localparam int ROW_BITS  = $clog2(GRID_ROWS);
  localparam int ADDR_BITS = $clog2(GRID_COLS * GRID_ROWS);
  localparam int CELLS     = GRID_COLS * GRID_ROWS;

  localparam int CMD_BITS   = 2;
  localparam int FCOL_BITS  = 6;
  localparam int FROW_BITS  = 6;
  localparam int CNT_BITS   = 7;
  localparam int DAMP_BITS  = 16;
  localparam int DEPTH_BITS = 15;

  localparam int CFG_INDEX_BITS = 1;
  localparam int CFG_DATA_BITS  = 16;

  localparam logic [DAMP_BITS-1:0]  DAMP_RESET  = DAMP_BITS'(262);
  localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = DEPTH_BITS'(100);

  // Four neighbors plus sign growth, and the damped value before saturation.
  localparam int SUM_BITS  = HEIGHT_BITS + 2;
  localparam int H_BITS    = HEIGHT_BITS + 2;
  localparam int PROD_BITS = H_BITS + DAMP_BITS + 1;
  localparam int RES_BITS  = H_BITS + 1;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_STEP  = 2'd0,
    CMD_LOWER = 2'd1,
    CMD_READ  = 2'd2
  } cmd_e;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_DAMPING     = 1'b0,
    REG_LOWER_DEPTH = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_STEP_A,
    S_STEP_B,
    S_STEP_C,
    S_STEP_D,
    S_STEP_E,
    S_LOWER,
    S_READ_A,
    S_READ_B,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_pair;
    logic load_h;
    logic load_prod;
  } calc_ctrl_t;

  function automatic logic [ADDR_BITS-1:0] cell_addr(input logic [ROW_BITS-1:0] row,
                                                     input logic [COL_BITS-1:0] col);
    return ADDR_BITS'(ADDR_BITS'(row) * ADDR_BITS'(GRID_COLS) + ADDR_BITS'(col));
  endfunction

  function automatic logic [COL_BITS-1:0] col_inc(input logic [COL_BITS-1:0] c);
    return (c == COL_BITS'(GRID_COLS - 1)) ? '0 : COL_BITS'(c + 1'b1);
  endfunction

  function automatic logic [COL_BITS-1:0] col_dec(input logic [COL_BITS-1:0] c);
    return (c == '0) ? COL_BITS'(GRID_COLS - 1) : COL_BITS'(c - 1'b1);
  endfunction

  function automatic logic [ROW_BITS-1:0] row_inc(input logic [ROW_BITS-1:0] r);
    return (r == ROW_BITS'(GRID_ROWS - 1)) ? '0 : ROW_BITS'(r + 1'b1);
  endfunction

  function automatic logic [ROW_BITS-1:0] row_dec(input logic [ROW_BITS-1:0] r);
    return (r == '0) ? ROW_BITS'(GRID_ROWS - 1) : ROW_BITS'(r - 1'b1);
  endfunction

endpackage

### design/wrg_in_if.sv
// Input channel of the ripple grid: one command word per handshake.
interface wrg_in_if
  import wrg_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [CMD_BITS-1:0]  cmd;
  logic [FCOL_BITS-1:0] first_col;
  logic [FROW_BITS-1:0] first_row;
  logic [CNT_BITS-1:0]  col_count;
  logic [CNT_BITS-1:0]  row_count;

  modport source (output valid, cmd, first_col, first_row, col_count, row_count,
                  input ready);
  modport sink (input valid, cmd, first_col, first_row, col_count, row_count,
                output ready);
endinterface

### design/wrg_out_if.sv
// Result channel of the ripple grid: one result word per handshake.
interface wrg_out_if
  import wrg_pkg::*;
();
  logic                          valid;
  logic                          ready;
  logic signed [HEIGHT_BITS-1:0] height;
  logic [CMD_BITS-1:0]           kind;

  modport source (output valid, height, kind, input ready);
  modport sink (input valid, height, kind, output ready);
endinterface

### design/wave_ripple_grid_step.sv
// Damped ripple on a 64 by 64 wrapped grid held in two 4096-word height memories.
// After reset the block sweeps both memories to zero, one cell a cycle, and takes
// no command word meanwhile; configuration writes go through at any time. A step
// word visits every cell in row order through one shared update unit, in states
// STEP_A to STEP_E per cell (left and right, then upper and lower neighbor reads
// over the two read ports of the current grid, then halving, the damping multiply
// and the write-back). A lower word writes one cell per cycle of its rectangle, a
// read word passes READ_A and READ_B; a result that waits for the sink holds up
// only the next word's result in S_DONE, not the acceptance of that word.
module wave_ripple_grid_step
  import wrg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  wrg_in_if.sink                    items,
  wrg_out_if.source                 results,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  state_t state, state_next;

  logic [DAMP_BITS-1:0]  damping_q16;
  logic [DEPTH_BITS-1:0] lower_depth;
  logic                  current_is_b;

  logic [CMD_BITS-1:0] cmd_reg;
  logic [COL_BITS-1:0] col_pos;
  logic [ROW_BITS-1:0] row_pos;
  logic [COL_BITS-1:0] base_col;
  logic [CNT_BITS-1:0] cols_left;
  logic [CNT_BITS-1:0] rows_left;
  logic [CNT_BITS-1:0] cols_span;

  logic signed [HEIGHT_BITS-1:0] res_height;
  logic                          out_valid;
  logic signed [HEIGHT_BITS-1:0] out_height;
  logic [CMD_BITS-1:0]           out_kind;

  logic [CNT_BITS-1:0] ncols_clamped;
  logic [CNT_BITS-1:0] nrows_clamped;
  logic                last_cell;
  logic                out_load;

  logic signed [HEIGHT_BITS-1:0] grid_a [CELLS];
  logic signed [HEIGHT_BITS-1:0] grid_b [CELLS];
  logic signed [HEIGHT_BITS-1:0] a_q0, a_q1, b_q0, b_q1;
  logic signed [HEIGHT_BITS-1:0] cur_q0, cur_q1, old_q;
  logic [ADDR_BITS-1:0]          cur_rd0, cur_rd1, old_rd;
  logic [ADDR_BITS-1:0]          a_rd0, b_rd0, wr_addr;
  logic                          cur_we, old_we, a_we, b_we;
  logic signed [HEIGHT_BITS-1:0] wdata;
  logic signed [HEIGHT_BITS-1:0] lower_val;
  logic signed [HEIGHT_BITS-1:0] calc_result;
  calc_ctrl_t                    calc_ctrl;

  assign ncols_clamped = (items.col_count > CNT_BITS'(GRID_COLS)) ?
                         CNT_BITS'(GRID_COLS) : items.col_count;
  assign nrows_clamped = (items.row_count > CNT_BITS'(GRID_ROWS)) ?
                         CNT_BITS'(GRID_ROWS) : items.row_count;
  assign last_cell = (col_pos == COL_BITS'(GRID_COLS - 1)) &&
                     (row_pos == ROW_BITS'(GRID_ROWS - 1));
  assign out_load  = (state == S_DONE) && (!out_valid || results.ready);
  assign lower_val = HEIGHT_BITS'(-$signed({1'b0, lower_depth}));

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (last_cell) state_next = S_IDLE;
      S_IDLE: begin
        if (items.valid) begin
          case (items.cmd)
            CMD_STEP: state_next = S_STEP_A;
            CMD_LOWER: begin
              if (ncols_clamped == '0 || nrows_clamped == '0) begin
                state_next = S_DONE;
              end else begin
                state_next = S_LOWER;
              end
            end
            CMD_READ: state_next = S_READ_A;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_STEP_A: state_next = S_STEP_B;
      S_STEP_B: state_next = S_STEP_C;
      S_STEP_C: state_next = S_STEP_D;
      S_STEP_D: state_next = S_STEP_E;
      S_STEP_E: state_next = last_cell ? S_DONE : S_STEP_A;
      S_LOWER: begin
        if (cols_left == CNT_BITS'(1) && rows_left == CNT_BITS'(1)) state_next = S_DONE;
      end
      S_READ_A: state_next = S_READ_B;
      S_READ_B: state_next = S_DONE;
      S_DONE:   if (out_load) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake, memory ports and update unit controls.
  always_comb begin
    items.ready = 1'b0;
    cur_rd0     = cell_addr(row_pos, col_pos);
    cur_rd1     = cell_addr(row_pos, col_inc(col_pos));
    old_rd      = cell_addr(row_pos, col_pos);
    cur_we      = 1'b0;
    old_we      = 1'b0;
    wdata       = '0;
    calc_ctrl   = '0;
    unique case (state)
      S_IDLE: items.ready = 1'b1;
      S_STEP_A: begin
        cur_rd0 = cell_addr(row_pos, col_dec(col_pos));
        cur_rd1 = cell_addr(row_pos, col_inc(col_pos));
      end
      S_STEP_B: begin
        cur_rd0 = cell_addr(row_dec(row_pos), col_pos);
        cur_rd1 = cell_addr(row_inc(row_pos), col_pos);
        calc_ctrl.load_pair = 1'b1;
      end
      S_STEP_C: calc_ctrl.load_h = 1'b1;
      S_STEP_D: calc_ctrl.load_prod = 1'b1;
      S_STEP_E: begin
        old_we = 1'b1;
        wdata  = calc_result;
      end
      S_LOWER: begin
        cur_we = 1'b1;
        wdata  = lower_val;
      end
      default: ;
    endcase
  end

  // Map the current and older grids onto the two memories.
  assign wr_addr = cell_addr(row_pos, col_pos);
  assign a_rd0   = current_is_b ? old_rd : cur_rd0;
  assign b_rd0   = current_is_b ? cur_rd0 : old_rd;
  assign a_we    = (state == S_CLEAR) || (current_is_b ? old_we : cur_we);
  assign b_we    = (state == S_CLEAR) || (current_is_b ? cur_we : old_we);
  assign cur_q0  = current_is_b ? b_q0 : a_q0;
  assign cur_q1  = current_is_b ? b_q1 : a_q1;
  assign old_q   = current_is_b ? a_q0 : b_q0;

  always_ff @(posedge clk) begin
    if (a_we) grid_a[wr_addr] <= wdata;
    a_q0 <= grid_a[a_rd0];
    a_q1 <= grid_a[cur_rd1];
  end

  always_ff @(posedge clk) begin
    if (b_we) grid_b[wr_addr] <= wdata;
    b_q0 <= grid_b[b_rd0];
    b_q1 <= grid_b[cur_rd1];
  end

  wrg_calc u_calc (
    .clk     (clk),
    .ctrl    (calc_ctrl),
    .damping (damping_q16),
    .q0      (cur_q0),
    .q1      (cur_q1),
    .old_q   (old_q),
    .result  (calc_result)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      damping_q16 <= DAMP_RESET;
      lower_depth <= DEPTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_reg_e'(cfg_index))
        REG_DAMPING:     damping_q16 <= cfg_data[DAMP_BITS-1:0];
        REG_LOWER_DEPTH: lower_depth <= cfg_data[DEPTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer registers and sweep counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      current_is_b <= 1'b0;
      col_pos      <= '0;
      row_pos      <= '0;
      cols_left    <= '0;
      rows_left    <= '0;
      cols_span    <= '0;
      base_col     <= '0;
      cmd_reg      <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_CLEAR, S_STEP_E: begin
          col_pos <= col_inc(col_pos);
          if (col_pos == COL_BITS'(GRID_COLS - 1)) row_pos <= row_inc(row_pos);
          if (state == S_STEP_E && last_cell) current_is_b <= !current_is_b;
        end
        S_IDLE: begin
          if (items.valid) begin
            cmd_reg <= items.cmd;
            if (items.cmd == CMD_STEP) begin
              col_pos <= '0;
              row_pos <= '0;
            end else begin
              col_pos <= COL_BITS'(items.first_col);
              row_pos <= ROW_BITS'(items.first_row);
            end
            base_col  <= COL_BITS'(items.first_col);
            cols_left <= ncols_clamped;
            cols_span <= ncols_clamped;
            rows_left <= nrows_clamped;
          end
        end
        S_LOWER: begin
          if (cols_left == CNT_BITS'(1)) begin
            cols_left <= cols_span;
            col_pos   <= base_col;
            rows_left <= rows_left - 1'b1;
            row_pos   <= row_inc(row_pos);
          end else begin
            cols_left <= cols_left - 1'b1;
            col_pos   <= col_inc(col_pos);
          end
        end
        default: ;
      endcase
    end
  end

  // Result word staging and the output register.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && items.valid) begin
      res_height <= '0;
    end else if (state == S_READ_B) begin
      res_height <= cur_q0;
    end
    if (out_load) begin
      out_height <= res_height;
      out_kind   <= cmd_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign results.valid  = out_valid;
  assign results.height = out_height;
  assign results.kind   = out_kind;

`ifndef NO_ASSERTIONS
  // Grid roles swap only when the last cell of a step has been written.
  a_swap_at_step_end: assert property (@(posedge clk) disable iff (rst)
    (current_is_b != $past(current_is_b)) |-> $past(state == S_STEP_E && last_cell))
    else $error("grid roles swapped outside the end of a step");

  // Both grids are written together only by the clearing sweep.
  a_dual_write_clear: assert property (@(posedge clk) disable iff (rst)
    (a_we && b_we) |-> (state == S_CLEAR))
    else $error("both grids written outside the clearing sweep");

  // Every accepted word leaves idle on the next cycle.
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    (items.valid && items.ready) |=> (state != S_IDLE))
    else $error("accepted word did not start work");

  // A new result appears only from the finishing state.
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(results.valid) |-> $past(state == S_DONE))
    else $error("result word loaded outside the finishing state");
`endif

endmodule

### design/wrg_calc.sv
// Shared cell update unit: neighbor sum, halving, damping multiply and saturation.
module wrg_calc
  import wrg_pkg::*;
(
  input  logic                          clk,
  input  calc_ctrl_t                    ctrl,
  input  logic [DAMP_BITS-1:0]          damping,
  input  logic signed [HEIGHT_BITS-1:0] q0,
  input  logic signed [HEIGHT_BITS-1:0] q1,
  input  logic signed [HEIGHT_BITS-1:0] old_q,
  output logic signed [HEIGHT_BITS-1:0] result
);

  logic signed [SUM_BITS-1:0]    pair_sum;
  logic signed [HEIGHT_BITS-1:0] old_h;
  logic signed [H_BITS-1:0]      h_reg;
  logic signed [PROD_BITS-1:0]   prod;

  logic signed [SUM_BITS-1:0]    sum4;
  logic signed [SUM_BITS-1:0]    sum_adj;
  logic signed [SUM_BITS-1:0]    half;
  logic signed [H_BITS-1:0]      h_next;
  logic signed [RES_BITS-1:0]    damp_part;
  logic signed [RES_BITS-1:0]    res;

  always_comb begin
    sum4 = pair_sum + SUM_BITS'(q0) + SUM_BITS'(q1);
    // Adding the sign bit before the shift makes the halving truncate toward zero.
    sum_adj = sum4 + $signed({{(SUM_BITS-1){1'b0}}, sum4[SUM_BITS-1]});
    half = sum_adj >>> 1;
    h_next = H_BITS'(half) - H_BITS'(old_h);
    // The arithmetic shift of the product is the floor of the Q16 scaling.
    damp_part = $signed(prod[PROD_BITS-1:16]);
    res = RES_BITS'(h_reg) - damp_part;
    if (res > RES_BITS'(2 ** (HEIGHT_BITS - 1) - 1)) begin
      result = {1'b0, {(HEIGHT_BITS-1){1'b1}}};
    end else if (res < -RES_BITS'(2 ** (HEIGHT_BITS - 1))) begin
      result = {1'b1, {(HEIGHT_BITS-1){1'b0}}};
    end else begin
      result = res[HEIGHT_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_pair) begin
      pair_sum <= SUM_BITS'(q0) + SUM_BITS'(q1);
      old_h    <= old_q;
    end
    if (ctrl.load_h) begin
      h_reg <= h_next;
    end
    if (ctrl.load_prod) begin
      prod <= PROD_BITS'(h_reg) * $signed({1'b0, damping});
    end
  end

endmodule

### sim/ripple_grid_monitor.sv
// Watches the ripple grid channels, predicts every result word and compares it.
module ripple_grid_monitor
  import wrg_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  wrg_in_if                         items,
  wrg_out_if                        results,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data,
  output int                        errors,
  output int                        pending
);

  typedef logic signed [HEIGHT_BITS-1:0] height_t;

  typedef struct packed {
    height_t             height;
    logic [CMD_BITS-1:0] kind;
  } reply_t;

  localparam longint HEIGHT_MAX = (longint'(1) << (HEIGHT_BITS - 1)) - 1;
  localparam longint HEIGHT_MIN = -HEIGHT_MAX - 1;

  height_t               plane [2][CELLS];
  logic                  cur_plane;
  logic [DAMP_BITS-1:0]  damping;
  logic [DEPTH_BITS-1:0] depth;
  reply_t                replies [$];

  function automatic height_t clamp_height(input longint v);
    if (v > HEIGHT_MAX) return height_t'(HEIGHT_MAX);
    if (v < HEIGHT_MIN) return height_t'(HEIGHT_MIN);
    return height_t'(v);
  endfunction

  // One timestep: the older plane is rebuilt from the current one, then they swap.
  function automatic void advance_wave();
    logic   older;
    int     rm, rp, cm, cp, idx;
    longint sum, h;
    older = ~cur_plane;
    for (int r = 0; r < GRID_ROWS; r++) begin
      rm = (r == 0) ? GRID_ROWS - 1 : r - 1;
      rp = (r == GRID_ROWS - 1) ? 0 : r + 1;
      for (int c = 0; c < GRID_COLS; c++) begin
        cm  = (c == 0) ? GRID_COLS - 1 : c - 1;
        cp  = (c == GRID_COLS - 1) ? 0 : c + 1;
        idx = r * GRID_COLS + c;
        sum = longint'(plane[cur_plane][r * GRID_COLS + cm])
            + longint'(plane[cur_plane][r * GRID_COLS + cp])
            + longint'(plane[cur_plane][rm * GRID_COLS + c])
            + longint'(plane[cur_plane][rp * GRID_COLS + c]);
        // Division truncates toward zero; the arithmetic shift floors the damping.
        h = sum / 2 - longint'(plane[older][idx]);
        h = h - ((h * longint'(damping)) >>> 16);
        plane[older][idx] = clamp_height(h);
      end
    end
    cur_plane = older;
  endfunction

  function automatic void press_rect(input logic [FCOL_BITS-1:0] col,
                                     input logic [FROW_BITS-1:0] row,
                                     input logic [CNT_BITS-1:0]  ncols,
                                     input logic [CNT_BITS-1:0]  nrows);
    int      span_c, span_r, slot;
    height_t v;
    span_c = (int'(ncols) > GRID_COLS) ? GRID_COLS : int'(ncols);
    span_r = (int'(nrows) > GRID_ROWS) ? GRID_ROWS : int'(nrows);
    v      = clamp_height(-longint'(depth));
    for (int j = 0; j < span_r; j++) begin
      for (int i = 0; i < span_c; i++) begin
        slot = ((int'(row) + j) % GRID_ROWS) * GRID_COLS + (int'(col) + i) % GRID_COLS;
        plane[cur_plane][slot] = v;
      end
    end
  endfunction

  always @(posedge clk) begin
    reply_t got;
    reply_t want;
    if (rst) begin
      for (int k = 0; k < CELLS; k++) begin
        plane[0][k] = '0;
        plane[1][k] = '0;
      end
      cur_plane = 1'b0;
      damping   = DAMP_RESET;
      depth     = DEPTH_RESET;
      replies.delete();
      errors    = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_DAMPING:     damping = cfg_data[DAMP_BITS-1:0];
          REG_LOWER_DEPTH: depth = cfg_data[DEPTH_BITS-1:0];
          default: ;
        endcase
      end

      if (results.valid && results.ready) begin
        got.height = results.height;
        got.kind   = results.kind;
        if (replies.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing due: height %0d kind %0d",
                   $time, $signed(got.height), got.kind);
        end else begin
          want = replies.pop_front();
          if (got.height !== want.height) begin
            errors++;
            $display("%0t: height expected %0d actual %0d",
                     $time, $signed(want.height), $signed(got.height));
          end
          if (got.kind !== want.kind) begin
            errors++;
            $display("%0t: kind expected %0d actual %0d", $time, want.kind, got.kind);
          end
        end
      end

      if (items.valid && items.ready) begin
        want.kind   = items.cmd;
        want.height = '0;
        case (items.cmd)
          CMD_STEP:  advance_wave();
          CMD_LOWER: press_rect(items.first_col, items.first_row,
                                items.col_count, items.row_count);
          CMD_READ:  want.height = plane[cur_plane][(int'(items.first_row) % GRID_ROWS)
                                   * GRID_COLS + int'(items.first_col) % GRID_COLS];
          default: ;
        endcase
        replies.push_back(want);
      end
    end
    pending = replies.size();
  end

endmodule

### sim/wave_ripple_grid_step_test.sv
// Top of the ripple grid testbench: clock, reset, command stimulus and verdict.
module wave_ripple_grid_step_test;
  import wrg_pkg::*;

  localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int PHASES      = 4;
  localparam int PHASE_ITEMS = 30;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        errors;
  int                        pending;
  int                        cycle_count = 0;
  bit                        no_idle = 1'b0;
  int                        steps_left = 22;
  int                        wide_left = 4;
  logic [FCOL_BITS-1:0]      hot_col = '0;
  logic [FROW_BITS-1:0]      hot_row = '0;

  wrg_in_if  in_ch ();
  wrg_out_if out_ch ();

  wave_ripple_grid_step dut (
    .clk,
    .rst,
    .items   (in_ch),
    .results (out_ch),
    .cfg_we,
    .cfg_index,
    .cfg_data
  );

  ripple_grid_monitor monitor (
    .clk,
    .rst,
    .items   (in_ch),
    .results (out_ch),
    .cfg_we,
    .cfg_index,
    .cfg_data,
    .errors,
    .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("wave_ripple_grid_step test failed");
      $finish;
    end
  end

  // Result side: a random stall before each word, none while no_idle is set.
  initial begin : sink_side
    int stall;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  task automatic send_word(input logic [CMD_BITS-1:0]  cmd,
                           input logic [FCOL_BITS-1:0] col,
                           input logic [FROW_BITS-1:0] row,
                           input logic [CNT_BITS-1:0]  ncols,
                           input logic [CNT_BITS-1:0]  nrows);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.cmd       <= cmd;
    in_ch.first_col <= col;
    in_ch.first_row <= row;
    in_ch.col_count <= ncols;
    in_ch.row_count <= nrows;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Waits until every word sent has been answered and the block sits idle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [CFG_DATA_BITS-1:0] damp,
                            input logic [CFG_DATA_BITS-1:0] depth_word);
    cfg_we    <= 1'b1;
    cfg_index <= REG_DAMPING;
    cfg_data  <= damp;
    @(posedge clk);
    cfg_index <= REG_LOWER_DEPTH;
    cfg_data  <= depth_word;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [CNT_BITS-1:0] draw_count();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 14) return CNT_BITS'($urandom_range(0, 8));
    if (pick < 17) return CNT_BITS'($urandom_range(9, 63));
    return CNT_BITS'($urandom_range(64, 127));
  endfunction

  function automatic int covered(input logic [CNT_BITS-1:0] n);
    return (int'(n) > 64) ? 64 : int'(n);
  endfunction

  task automatic random_word();
    int                   pick;
    logic [FCOL_BITS-1:0] c;
    logic [FROW_BITS-1:0] r;
    logic [CNT_BITS-1:0]  nc;
    logic [CNT_BITS-1:0]  nr;
    pick = $urandom_range(0, 99);
    c    = FCOL_BITS'($urandom_range(0, 63));
    r    = FROW_BITS'($urandom_range(0, 63));
    nc   = CNT_BITS'($urandom_range(0, 127));
    nr   = CNT_BITS'($urandom_range(0, 127));
    if (pick < 15 && steps_left > 0) begin
      steps_left--;
      send_word(CMD_STEP, c, r, nc, nr);
    end else if (pick >= 15 && pick < 50) begin
      nc = draw_count();
      nr = draw_count();
      // Big rectangles cost a cycle per cell, so only a few are let through.
      if (covered(nc) * covered(nr) > 512) begin
        if (wide_left > 0) wide_left--;
        else nr = CNT_BITS'($urandom_range(0, 8));
      end
      hot_col = c;
      hot_row = r;
      send_word(CMD_LOWER, c, r, nc, nr);
    end else if (pick < 95) begin
      // Most reads land near the last rectangle, where the ripple lives.
      if ($urandom_range(0, 9) < 6) begin
        c = hot_col + FCOL_BITS'($urandom_range(0, 15)) - FCOL_BITS'(4);
        r = hot_row + FROW_BITS'($urandom_range(0, 15)) - FROW_BITS'(4);
      end
      send_word(CMD_READ, c, r, nc, nr);
    end else begin
      send_word(CMD_UNUSED, c, r, nc, nr);
    end
  endtask

  initial begin
    rst             <= 1'b1;
    cfg_we          <= 1'b0;
    cfg_index       <= REG_DAMPING;
    cfg_data        <= '0;
    in_ch.valid     <= 1'b0;
    in_ch.cmd       <= CMD_STEP;
    in_ch.first_col <= '0;
    in_ch.first_row <= '0;
    in_ch.col_count <= '0;
    in_ch.row_count <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Reset configuration first: empty grid, wrapped corner, zero and oversized counts.
    send_word(CMD_READ, 6'd0, 6'd0, 7'd0, 7'd0);
    send_word(CMD_READ, 6'd63, 6'd63, 7'd127, 7'd127);
    send_word(CMD_UNUSED, 6'd63, 6'd0, 7'd127, 7'd0);
    send_word(CMD_LOWER, 6'd5, 6'd5, 7'd0, 7'd3);
    send_word(CMD_LOWER, 6'd5, 6'd5, 7'd3, 7'd0);
    send_word(CMD_LOWER, 6'd62, 6'd62, 7'd4, 7'd4);
    send_word(CMD_READ, 6'd63, 6'd63, 7'd0, 7'd0);
    send_word(CMD_READ, 6'd1, 6'd1, 7'd0, 7'd0);
    send_word(CMD_LOWER, 6'd10, 6'd20, 7'd127, 7'd1);
    send_word(CMD_LOWER, 6'd30, 6'd0, 7'd1, 7'd64);
    send_word(CMD_STEP, 6'd0, 6'd0, 7'd0, 7'd0);
    send_word(CMD_READ, 6'd0, 6'd0, 7'd0, 7'd0);
    send_word(CMD_STEP, 6'd63, 6'd63, 7'd127, 7'd127);
    send_word(CMD_READ, 6'd30, 6'd21, 7'd0, 7'd0);
    drain();

    // Strongest damping and deepest press; the damping flattens every height a step writes.
    write_regs(16'hFFFF, 16'h7FFF);
    send_word(CMD_LOWER, 6'd32, 6'd32, 7'd3, 7'd3);
    send_word(CMD_STEP, 6'd0, 6'd0, 7'd0, 7'd0);
    send_word(CMD_STEP, 6'd0, 6'd0, 7'd0, 7'd0);
    send_word(CMD_READ, 6'd33, 6'd33, 7'd0, 7'd0);
    send_word(CMD_READ, 6'd31, 6'd32, 7'd0, 7'd0);
    drain();

    // No damping and zero depth; the top data bit lies outside the depth register.
    write_regs(16'h0000, 16'h8000);
    send_word(CMD_LOWER, 6'd0, 6'd0, 7'd2, 7'd2);
    send_word(CMD_STEP, 6'd0, 6'd0, 7'd0, 7'd0);
    send_word(CMD_READ, 6'd0, 6'd0, 7'd0, 7'd0);
    send_word(CMD_READ, 6'd33, 6'd33, 7'd0, 7'd0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       write_regs(CFG_DATA_BITS'($urandom), CFG_DATA_BITS'($urandom));
        1:       write_regs(16'hFFFF, 16'hFFFF);
        2:       write_regs(16'h0000, CFG_DATA_BITS'($urandom));
        default: write_regs(CFG_DATA_BITS'($urandom_range(0, 4095)),
                            CFG_DATA_BITS'($urandom));
      endcase
      no_idle = (ph == 2);
      repeat (PHASE_ITEMS) random_word();
      drain();
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("wave_ripple_grid_step test passed");
    end else begin
      $display("wave_ripple_grid_step test failed");
    end
    $finish;
  end

endmodule

### wave_ripple_grid_step.f
design/wrg_pkg.sv
design/wrg_in_if.sv
design/wrg_out_if.sv
design/wrg_calc.sv
design/wave_ripple_grid_step.sv
sim/ripple_grid_monitor.sv
sim/wave_ripple_grid_step_test.sv
